[src/clbc_pkg.sv]
// Shared types, constants and the BCD conversion step for the card number check.
package clbc_pkg;

	localparam int CardW   = 63;
	localparam int BinW    = 64;               // card number padded to an even width
	localparam int NumDig  = 19;
	localparam int BcdW    = 4 * NumDig;
	localparam int CountW  = 5;
	localparam int VerdW   = 2;
	localparam int ConvW   = 5;                // two bits per step, BinW/2 steps
	localparam int ConvSteps = BinW / 2;

	localparam logic [VerdW-1:0] VerdictInvalid = 2'd0;
	localparam logic [VerdW-1:0] VerdictVisa    = 2'd1;
	localparam logic [VerdW-1:0] VerdictAmex    = 2'd2;
	localparam logic [VerdW-1:0] VerdictMc      = 2'd3;

	typedef logic [BcdW-1:0]   bcd_t;
	typedef logic [3:0]        digit_t;
	typedef logic [CountW-1:0] count_t;

	typedef struct packed {
		logic [VerdW-1:0] verdict;
		count_t           digit_count;
	} result_t;

	// one double-dabble step: correct every digit, then shift in one bit
	function automatic bcd_t dabble(input bcd_t bcd, input logic bin_bit);
		bcd_t fixed;
		fixed = bcd;
		for (int k = 0; k < NumDig; k++) begin
			if (bcd[4*k +: 4] >= 4'd5) begin
				fixed[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
			end
		end
		return {fixed[BcdW-2:0], bin_bit};
	endfunction

endpackage

[src/clbc_card_if.sv]
// Input channel: one card number word.
interface clbc_card_if;
	logic                         valid;
	logic                         ready;
	logic [clbc_pkg::CardW-1:0]   card_number;

	modport source (output valid, output card_number, input ready);
	modport sink (input valid, input card_number, output ready);
endinterface

[src/clbc_verdict_if.sv]
// Output channel: verdict and digit count word.
interface clbc_verdict_if;
	logic                          valid;
	logic                          ready;
	logic [clbc_pkg::VerdW-1:0]    verdict;
	logic [clbc_pkg::CountW-1:0]   digit_count;

	modport source (output valid, output verdict, output digit_count, input ready);
	modport sink (input valid, input verdict, input digit_count, output ready);
endinterface

[src/card_number_luhn_brand_check.sv]
// Card number check: count digits, recognise brand, Luhn mod-10 check.
// Each accepted word passes in turn through start, convert, scan and hand-off to the output register.
// A new word is taken only after the previous result has left HOLD, so words do not overlap; a stalled
//   output holds that hand-off back. Conversion uses the two-bit-per-cycle BCD converter and the
//   scan the one-digit-per-cycle scanner.
// Reset: arst_n clears the sequencer and the output valid; data registers are not reset.
module card_number_luhn_brand_check (
	input  logic                  clk,
	input  logic                  arst_n,
	clbc_card_if.sink             card_in,
	clbc_verdict_if.source        res_out
);

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CONV = 4'b0010,
		S_SCAN = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t              state_q;
	logic                in_fire;
	logic                conv_done;
	logic                scan_done;
	logic                load_out;
	clbc_pkg::bcd_t      bcd;
	clbc_pkg::result_t   scan_res;
	clbc_pkg::result_t   out_q;
	logic                out_valid_q;

	// a new word is taken only in IDLE, even while the output register still holds a result
	assign card_in.ready = (state_q == S_IDLE);
	assign in_fire       = card_in.valid && card_in.ready;

	// the scanner's result is parked in HOLD until the output register frees up
	assign load_out = (state_q == S_HOLD) && (!out_valid_q || res_out.ready);

	// converter: iterative dabble unit, two bits a cycle
	clbc_b2d u_b2d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.value  (card_in.card_number),
		.bcd    (bcd),
		.done   (conv_done)
	);

	// scanner: one digit a cycle, Luhn sum plus length and leading digits
	clbc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_done),
		.bcd    (bcd),
		.result (scan_res),
		.done   (scan_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_CONV;
				end
				S_CONV: begin
					if (conv_done) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_done) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= scan_res;
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.verdict     = out_q.verdict;
	assign res_out.digit_count = out_q.digit_count;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_CONV)
		else $error("accepted word did not start conversion");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.digit_count <= 5'd19)
		else $error("digit count out of range");

	a_brand_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.verdict != clbc_pkg::VerdictInvalid) |->
		(out_q.digit_count == 5'd13 || out_q.digit_count == 5'd15 ||
		out_q.digit_count == 5'd16))
		else $error("brand reported for an impossible length");

	a_amex_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.verdict == clbc_pkg::VerdictAmex) |->
		out_q.digit_count == 5'd15)
		else $error("Amex verdict with wrong length");

endmodule

[src/clbc_b2d.sv]
// Iterative binary to BCD converter, two bits per cycle.
module clbc_b2d (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [clbc_pkg::CardW-1:0] value,
	output clbc_pkg::bcd_t             bcd,
	output logic                       done
);

	logic [clbc_pkg::BinW-1:0] bin_q;
	clbc_pkg::bcd_t            bcd_q;
	logic [clbc_pkg::ConvW-1:0] step_q;
	logic                      busy_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == clbc_pkg::ConvW'(clbc_pkg::ConvSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= {1'b0, value};
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[clbc_pkg::BinW-3:0], 2'b00};
			bcd_q <= clbc_pkg::dabble(clbc_pkg::dabble(bcd_q, bin_q[clbc_pkg::BinW-1]),
				bin_q[clbc_pkg::BinW-2]);
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

[src/clbc_scan.sv]
// Digit scanner: one BCD digit per cycle for Luhn sum, length and leading digits.
module clbc_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  clbc_pkg::bcd_t      bcd,
	output clbc_pkg::result_t   result,
	output logic                done
);

	clbc_pkg::bcd_t    bcd_q;
	clbc_pkg::count_t  idx_q;
	clbc_pkg::count_t  count_q;
	clbc_pkg::digit_t  sum_q;
	clbc_pkg::digit_t  prev_q;
	clbc_pkg::digit_t  lead_q;
	clbc_pkg::digit_t  sec_q;
	logic              busy_q;
	logic              done_q;

	clbc_pkg::digit_t  dig;
	logic [4:0]        dbl;
	clbc_pkg::digit_t  term;
	logic [4:0]        acc;

	always_comb begin
		dig = bcd_q[3:0];
		dbl = {dig, 1'b0};
		if (idx_q[0]) begin
			term = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			term = dig;
		end
		acc = {1'b0, sum_q} + {1'b0, term};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == clbc_pkg::CountW'(clbc_pkg::NumDig - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bcd_q   <= bcd;
			count_q <= '0;
			sum_q   <= '0;
			prev_q  <= '0;
			lead_q  <= '0;
			sec_q   <= '0;
		end else if (busy_q) begin
			bcd_q  <= {4'd0, bcd_q[clbc_pkg::BcdW-1:4]};
			sum_q  <= (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
			prev_q <= dig;
			if (dig != 4'd0) begin
				count_q <= idx_q + 1'b1;
				lead_q  <= dig;
				sec_q   <= prev_q;
			end
		end
	end

	// brand by length and leading digits, gated by the Luhn sum
	logic [clbc_pkg::VerdW-1:0] brand;
	always_comb begin
		brand = clbc_pkg::VerdictInvalid;
		if (count_q == 5'd13 && lead_q == 4'd4) begin
			brand = clbc_pkg::VerdictVisa;
		end else if (count_q == 5'd15 && lead_q == 4'd3 &&
				(sec_q == 4'd4 || sec_q == 4'd7)) begin
			brand = clbc_pkg::VerdictAmex;
		end else if (count_q == 5'd16 && lead_q == 4'd5 &&
				sec_q >= 4'd1 && sec_q <= 4'd5) begin
			brand = clbc_pkg::VerdictMc;
		end else if (count_q == 5'd16 && lead_q == 4'd4) begin
			brand = clbc_pkg::VerdictVisa;
		end
		result.verdict     = (sum_q == 4'd0) ? brand : clbc_pkg::VerdictInvalid;
		result.digit_count = count_q;
	end

	assign done = done_q;

endmodule
